>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL of the vibrator sequencer.
// Depends on nothing; expects clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/tvos_pkg.sv
// Types and constants for the timed vibrator overdrive sequencer.
// No dependencies; used by tvos_seq_core and the top level.
package tvos_pkg;

  typedef enum logic [1:0] {
    PH_OFF   = 2'd0,
    PH_MAIN  = 2'd1,
    PH_OVER  = 2'd2,
    PH_BRAKE = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] count;
    logic        tail;
    logic [5:0]  level;
  } seq_state_t;

  typedef struct packed {
    logic [6:0]  gain_level;
    logic [15:0] max_duration_ms;
    logic        clamp_enable;
  } seq_cfg_t;

  localparam logic [1:0] CFG_GAIN_LEVEL   = 2'd0;
  localparam logic [1:0] CFG_MAX_DURATION = 2'd1;
  localparam logic [1:0] CFG_CLAMP_ENABLE = 2'd2;

  localparam logic [6:0]  GAIN_RESET      = 7'd60;
  localparam logic [15:0] MAX_DUR_RESET   = 16'd30000;
  localparam logic        CLAMP_RESET     = 1'b1;

  localparam logic       CMD_TICK        = 1'b0;
  localparam logic       CMD_ENABLE      = 1'b1;

  localparam logic [5:0]  LEVEL_MAX       = 6'd63;
  localparam logic [5:0]  LEVEL_OVERDRIVE = 6'd52;
  localparam logic [5:0]  LEVEL_BRAKE     = 6'd2;
  localparam logic [15:0] OVERDRIVE_MS    = 16'd30;
  localparam logic [15:0] TAIL_TOTAL_MS   = 16'd20;
  localparam logic [15:0] TAIL_SEG_MS     = 16'd10;

endpackage

>>> hw/rtl/timed_vibrator_overdrive_sequencer_top.sv
// Latency: a result is valid in the cycle after the input transfer.
// Throughput: one item per cycle while out_ready is high; the output register frees itself when taken.
// The sequencer state is updated by tvos_seq_core at every input transfer.
// Reset (synchronous, active low) clears the sequence and out_valid (the output
// data registers are not reset) and loads gain 60, max 30000 ms, clamp on.
module timed_vibrator_overdrive_sequencer_top
  import tvos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_duration_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_motor_on,
  output logic [5:0]  out_duty_level,
  output logic [15:0] out_remaining_ms
);

`include "assert_macros.svh"

  seq_cfg_t    cfg_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  logic        out_valid_r;
  logic        out_motor_on_r;
  logic [5:0]  out_duty_level_r;
  logic [15:0] out_remaining_ms_r;
  logic        in_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_level      <= GAIN_RESET;
      cfg_r.max_duration_ms <= MAX_DUR_RESET;
      cfg_r.clamp_enable    <= CLAMP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN_LEVEL:   cfg_r.gain_level      <= cfg_wdata[6:0];
        CFG_MAX_DURATION: cfg_r.max_duration_ms <= cfg_wdata;
        CFG_CLAMP_ENABLE: cfg_r.clamp_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tvos_seq_core u_core (
    .cur         (state_r),
    .cfg         (cfg_r),
    .cmd         (in_cmd),
    .duration_ms (in_duration_ms),
    .nxt         (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= PH_OFF;
      state_r.count <= 16'd0;
      state_r.tail  <= 1'b0;
      state_r.level <= 6'd0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_motor_on_r     <= (state_nxt.level != 6'd0);
      out_duty_level_r   <= state_nxt.level;
      out_remaining_ms_r <= state_nxt.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_motor_on     = out_motor_on_r;
  assign out_duty_level   = out_duty_level_r;
  assign out_remaining_ms = out_remaining_ms_r;

  `ASSERT_CLK(a_motor_matches_level, out_valid_r |-> (out_motor_on_r == (out_duty_level_r != 6'd0)), "motor enable disagrees with duty level")
  `ASSERT_ALWAYS(a_off_is_clear, (state_r.phase == PH_OFF) |-> (state_r.count == 16'd0 && state_r.level == 6'd0 && !state_r.tail), "idle state not cleared")
  `ASSERT_CLK(a_tail_segment_bounds, (state_r.phase == PH_OVER || state_r.phase == PH_BRAKE) |-> (state_r.count != 16'd0 && state_r.count <= TAIL_SEG_MS), "tail segment count out of range")
  `ASSERT_CLK(a_idle_tick_stays_off, (in_xfer && in_cmd == CMD_TICK && state_r.phase == PH_OFF) |=> (state_r.phase == PH_OFF), "tick woke an idle sequencer")

endmodule

>>> hw/rtl/tvos_seq_core.sv
// Next-state logic of the vibrator sequencer for one transferred item.
// Depends on tvos_pkg.
module tvos_seq_core
  import tvos_pkg::*;
(
  input  seq_state_t  cur,
  input  seq_cfg_t    cfg,
  input  logic        cmd,
  input  logic [15:0] duration_ms,
  output seq_state_t  nxt
);

  logic [15:0] dur_clamped;
  logic        req_off;
  logic        req_long;
  logic        seg_done;
  logic [5:0]  gain_sat;
  phase_t      phase_nxt;

  always_comb begin
    dur_clamped = duration_ms;
    if (cfg.clamp_enable && (duration_ms > cfg.max_duration_ms)) begin
      dur_clamped = cfg.max_duration_ms;
    end
    req_off  = (dur_clamped == 16'd0);
    req_long = (dur_clamped > OVERDRIVE_MS);
    seg_done = (cur.count <= 16'd1);
    gain_sat = (cfg.gain_level > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : cfg.gain_level[5:0];
  end

  always_comb begin
    phase_nxt = cur.phase;
    if (cmd == CMD_ENABLE) begin
      phase_nxt = req_off ? PH_OFF : PH_MAIN;
    end else if (seg_done) begin
      unique case (cur.phase)
        PH_OFF:   phase_nxt = PH_OFF;
        PH_MAIN:  phase_nxt = cur.tail ? PH_OVER : PH_OFF;
        PH_OVER:  phase_nxt = PH_BRAKE;
        PH_BRAKE: phase_nxt = PH_OFF;
        default:  phase_nxt = PH_OFF;
      endcase
    end
  end

  always_comb begin
    nxt.phase = phase_nxt;
    nxt.count = cur.count;
    nxt.tail  = cur.tail;
    nxt.level = cur.level;
    if (cmd == CMD_ENABLE) begin
      if (req_off) begin
        nxt.count = 16'd0;
        nxt.tail  = 1'b0;
        nxt.level = 6'd0;
      end else begin
        nxt.count = req_long ? (dur_clamped - TAIL_TOTAL_MS) : dur_clamped;
        nxt.tail  = req_long;
        nxt.level = gain_sat;
      end
    end else if (cur.phase != PH_OFF) begin
      if (!seg_done) begin
        nxt.count = cur.count - 16'd1;
      end else if (cur.phase == PH_MAIN && cur.tail) begin
        nxt.count = TAIL_SEG_MS;
        nxt.level = LEVEL_OVERDRIVE;
      end else if (cur.phase == PH_OVER) begin
        nxt.count = TAIL_SEG_MS;
        nxt.level = LEVEL_BRAKE;
      end else begin
        nxt.count = 16'd0;
        nxt.tail  = 1'b0;
        nxt.level = 6'd0;
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for timed_vibrator_overdrive_sequencer_top.
// Uses tvos_pkg for codes and levels. A directed table and random command streams are
// checked against a cycle-free motor predictor under several idle and stall mixes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tvos_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 240;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic        motor_on;
    logic [5:0]  duty;
    logic [15:0] remaining;
  } drive_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [1:0]  idx;
    logic [15:0] value;
    int          reps;
    logic        fixed;
    logic        exp_on;
    logic [5:0]  exp_duty;
    logic [15:0] exp_rem;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_GAIN_LEVEL;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_TICK;
  logic [15:0] in_duration_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_motor_on;
  logic [5:0]  out_duty_level;
  logic [15:0] out_remaining_ms;

  logic   in_fixed = 1'b0;
  drive_t in_fixed_exp = '0;

  drive_t drive_q[$];
  int     errors = 0;
  int     cycle_count = 0;
  int     items_sent = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_len = 0;

  phase_t      vib_phase = PH_OFF;
  logic [15:0] seg_left = '0;
  logic        tail_armed = 1'b0;
  logic [5:0]  level_applied = '0;
  logic [6:0]  gain_reg = GAIN_RESET;
  logic [15:0] max_ms_reg = MAX_DUR_RESET;
  logic        clamp_reg = CLAMP_RESET;

  plan_row_t plan [25];

  timed_vibrator_overdrive_sequencer_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_duration_ms   (in_duration_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_motor_on     (out_motor_on),
    .out_duty_level   (out_duty_level),
    .out_remaining_ms (out_remaining_ms)
  );

  always #6 clk = ~clk;

  function automatic void stop_motor();
    vib_phase = PH_OFF;
    seg_left = '0;
    tail_armed = 1'b0;
    level_applied = '0;
  endfunction

  function automatic drive_t advance_motor(input logic cmd, input logic [15:0] dur);
    logic [15:0] d;
    drive_t r;
    d = dur;
    if (cmd == CMD_ENABLE) begin
      if (clamp_reg && d > max_ms_reg) d = max_ms_reg;
      if (d == '0) begin
        stop_motor();
      end else begin
        if (d > OVERDRIVE_MS) begin
          seg_left = d - TAIL_TOTAL_MS;
          tail_armed = 1'b1;
        end else begin
          seg_left = d;
          tail_armed = 1'b0;
        end
        level_applied = (gain_reg > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : gain_reg[5:0];
        vib_phase = PH_MAIN;
      end
    end else if (vib_phase != PH_OFF) begin
      if (seg_left > 16'd1) begin
        seg_left = seg_left - 16'd1;
      end else if (vib_phase == PH_MAIN && tail_armed) begin
        vib_phase = PH_OVER;
        level_applied = LEVEL_OVERDRIVE;
        seg_left = TAIL_SEG_MS;
      end else if (vib_phase == PH_OVER) begin
        vib_phase = PH_BRAKE;
        level_applied = LEVEL_BRAKE;
        seg_left = TAIL_SEG_MS;
      end else begin
        stop_motor();
      end
    end
    r.motor_on = (level_applied != '0);
    r.duty = level_applied;
    r.remaining = seg_left;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 50)
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
  endtask

  always @(posedge clk) begin
    drive_t e;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end else if (!rst_n) begin
      stop_motor();
      gain_reg = GAIN_RESET;
      max_ms_reg = MAX_DUR_RESET;
      clamp_reg = CLAMP_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          report("unexpected result", out_remaining_ms, 0);
        end else begin
          e = drive_q.pop_front();
          if (out_motor_on !== e.motor_on) report("motor_on", out_motor_on, e.motor_on);
          if (out_duty_level !== e.duty) report("duty_level", out_duty_level, e.duty);
          if (out_remaining_ms !== e.remaining)
            report("remaining_ms", out_remaining_ms, e.remaining);
        end
      end
      if (in_valid && in_ready) begin
        e = advance_motor(in_cmd, in_duration_ms);
        drive_q.push_back(in_fixed ? in_fixed_exp : e);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GAIN_LEVEL:   gain_reg = cfg_wdata[6:0];
          CFG_MAX_DURATION: max_ms_reg = cfg_wdata;
          CFG_CLAMP_ENABLE: clamp_reg = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic cmd, input logic [15:0] dur, input logic fixed,
                           input drive_t exp_val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_duration_ms <= dur;
    in_fixed <= fixed;
    in_fixed_exp <= exp_val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_duration();
    int roll;
    int corner;
    roll = $urandom_range(99);
    corner = $urandom_range(6);
    if (roll < 45) return 16'($urandom_range(1, 60));
    if (roll < 60) return (corner < 3) ? 16'(corner) : 16'(26 + corner);
    if (roll < 75) return 16'($urandom_range(61, 150));
    if (roll < 90) return 16'($urandom);
    return '0;
  endfunction

  task automatic play_sequence();
    logic [15:0] dur;
    int ticks;
    if ($urandom_range(99) < 80) begin
      dur = pick_duration();
      send_item(CMD_ENABLE, dur, 1'b0, '0);
      ticks = (dur > 16'd100) ? 100 : int'(dur) + 2;
      if ($urandom_range(1) == 0) ticks = $urandom_range(0, ticks);
      repeat (ticks) send_item(CMD_TICK, 16'($urandom), 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 5)) send_item(1'($urandom), 16'($urandom), 1'b0, '0);
    end
  endtask

  task automatic reconfigure();
    int roll;
    logic [15:0] gain_val;
    logic [15:0] max_val;
    settle();
    case ($urandom_range(4))
      0: gain_val = 16'd0;
      1: gain_val = 16'd63;
      2: gain_val = 16'd64;
      3: gain_val = 16'd127;
      default: gain_val = 16'($urandom_range(0, 127));
    endcase
    roll = $urandom_range(99);
    if (roll < 40) max_val = 16'hFFFF;
    else if (roll < 55) max_val = 16'($urandom_range(0, 100));
    else if (roll < 65) max_val = '0;
    else if (roll < 75) max_val = 16'($urandom_range(30, 31));
    else max_val = 16'($urandom);
    write_reg(CFG_GAIN_LEVEL, gain_val);
    write_reg(CFG_MAX_DURATION, max_val);
    write_reg(CFG_CLAMP_ENABLE, 16'($urandom));
    if ($urandom_range(9) == 0) write_reg(CFG_UNUSED, 16'($urandom));
  endtask

  initial begin
    int phase_end;
    drive_t typed;
    plan = '{
      '{ROW_ITEM, CMD_TICK,   CFG_GAIN_LEVEL,   16'hFFFF, 1,  1'b1, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd0,    1,  1'b1, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd5,    1,  1'b1, 1'b1, 6'd60, 16'd5},
      '{ROW_ITEM, CMD_TICK,   CFG_GAIN_LEVEL,   16'd0,    5,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd31,   1,  1'b1, 1'b1, 6'd60, 16'd11},
      '{ROW_ITEM, CMD_TICK,   CFG_GAIN_LEVEL,   16'd0,    31, 1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd30,   1,  1'b1, 1'b1, 6'd60, 16'd30},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'hFFFF, 1,  1'b1, 1'b1, 6'd60, 16'd29980},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd100,  1,  1'b1, 1'b1, 6'd60, 16'd80},
      '{ROW_CFG,  CMD_TICK,   CFG_GAIN_LEVEL,   16'd64,   1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_TICK,   CFG_GAIN_LEVEL,   16'd0,    3,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd1,    1,  1'b1, 1'b1, 6'd63, 16'd1},
      '{ROW_ITEM, CMD_TICK,   CFG_GAIN_LEVEL,   16'd0,    1,  1'b1, 1'b0, 6'd0,  16'd0},
      '{ROW_CFG,  CMD_TICK,   CFG_GAIN_LEVEL,   16'd0,    1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd40,   1,  1'b1, 1'b0, 6'd0,  16'd20},
      '{ROW_ITEM, CMD_TICK,   CFG_GAIN_LEVEL,   16'd0,    41, 1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_CFG,  CMD_TICK,   CFG_MAX_DURATION, 16'd0,    1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd7,    1,  1'b1, 1'b0, 6'd0,  16'd0},
      '{ROW_CFG,  CMD_TICK,   CFG_CLAMP_ENABLE, 16'd0,    1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_CFG,  CMD_TICK,   CFG_GAIN_LEVEL,   16'd127,  1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'hFFFF, 1,  1'b1, 1'b1, 6'd63, 16'd65515},
      '{ROW_CFG,  CMD_TICK,   CFG_MAX_DURATION, 16'hFFFF, 1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_CFG,  CMD_TICK,   CFG_CLAMP_ENABLE, 16'd1,    1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_CFG,  CMD_TICK,   CFG_GAIN_LEVEL,   16'd60,   1,  1'b0, 1'b0, 6'd0,  16'd0},
      '{ROW_ITEM, CMD_ENABLE, CFG_GAIN_LEVEL,   16'd31,   1,  1'b1, 1'b1, 6'd60, 16'd11}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        typed = '{plan[i].exp_on, plan[i].exp_duty, plan[i].exp_rem};
        repeat (plan[i].reps) send_item(plan[i].cmd, plan[i].value, plan[i].fixed, typed);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == 0) begin
        // Receiver holds off long enough for the output register to fill and stall the input.
        hold_len = 400;
        send_item(CMD_ENABLE, pick_duration(), 1'b0, '0);
        repeat (12) send_item(CMD_TICK, 16'($urandom), 1'b0, '0);
        settle();
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(7) == 0) reconfigure();
        play_sequence();
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (drive_q.size() != 0) report("results never delivered", 0, drive_q.size());
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
